// ----- hw/rtl/msd_pkg.sv -----
// Package for the multi-server task dispatcher: payload structs, event codes
// and fixed sizes. No dependencies.
`timescale 1ns / 1ps

package msd_pkg;

  // Fixed sizes set by the field widths of the result items.
  localparam int unsigned NUM_SERVERS = 8;
  localparam int unsigned NUM_QUEUES  = 4;
  localparam int unsigned SRV_W       = 3;
  localparam int unsigned Q_W         = 2;
  localparam int unsigned TASK_W      = 16;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned WAIT_W      = 16;
  localparam int unsigned ASRV_W      = 4;
  localparam int unsigned AQ_W        = 3;

  // Event kinds of a result item.
  localparam logic [1:0] EV_FREE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // Register indexes.
  localparam logic REG_ACTIVE_SERVERS = 1'b0;
  localparam logic REG_ACTIVE_QUEUES  = 1'b1;

  typedef struct packed {
    logic              new_task_valid;
    logic [Q_W-1:0]    queue_index;
    logic [DUR_W-1:0]  duration;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [SRV_W-1:0]  server_index;
    logic [TASK_W-1:0] task_id;
    logic [Q_W-1:0]    source_queue;
    logic [WAIT_W-1:0] wait_ticks;
    logic              task_dropped;
    logic              last;
  } out_item_t;

  // A tick as classified by the front part.
  typedef struct packed {
    in_item_t item;
    logic     inactive;
  } cmd_t;

  // Configuration seen by the back part.
  typedef struct packed {
    logic [ASRV_W-1:0] active_servers;
    logic [AQ_W-1:0]   active_queues;
    logic              refill;
  } cfg_t;

endpackage

// ----- hw/rtl/msd_front.sv -----
// Front part of the dispatcher: accepts ticks, marks tasks for inactive
// queues, and holds them in a two-entry queue. Depends on msd_pkg.
`timescale 1ns / 1ps

module msd_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  msd_pkg::in_item_t       in_data_i,
  input  logic [msd_pkg::AQ_W-1:0] active_queues_i,
  output logic                    cmd_valid_o,
  input  logic                    cmd_pop_i,
  output msd_pkg::cmd_t           cmd_o
);
  import msd_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  cmd_t       cls;

  // Classify the incoming tick.
  always_comb begin
    cls.item     = in_data_i;
    cls.inactive = {1'b0, in_data_i.queue_index} >= active_queues_i;
  end

  assign in_ready_o  = count_q != 2'd2;
  assign cmd_valid_o = count_q != 2'd0;
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  // Pointer and count update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- hw/rtl/msd_engine.sv -----
// Back part of the dispatcher: per tick it enqueues the task, counts servers
// down and loads free servers, emitting results. Depends on msd_pkg.
`timescale 1ns / 1ps

module msd_engine #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msd_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  input  msd_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msd_pkg::out_item_t out_data_o
);
  import msd_pkg::*;

  localparam int unsigned HEAD_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MEM_D  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(MEM_D);
  localparam int unsigned ENT_W  = TASK_W + TIME_BITS + DUR_W;
  localparam int unsigned SCNT_W = $clog2(NUM_SERVERS + 1);
  localparam int unsigned QCNT_W = $clog2(NUM_QUEUES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ENQ   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [DUR_W-1:0]     rem_q [NUM_SERVERS];
  logic                 busy_q [NUM_SERVERS];
  logic [TASK_W-1:0]    stask_q [NUM_SERVERS];
  logic [SRV_W-1:0]     ffifo_q [NUM_SERVERS];
  logic [SCNT_W-1:0]    fcount_q;
  logic [FILL_W-1:0]    fill_q [NUM_QUEUES];
  logic [HEAD_W-1:0]    head_q [NUM_QUEUES];
  logic [TIME_BITS-1:0] tick_q;
  logic [TASK_W-1:0]    seq_q;
  logic [SCNT_W-1:0]    sptr_q;
  logic [QCNT_W-1:0]    qptr_q;
  logic                 drop_q;
  logic [ENT_W-1:0]     mem [MEM_D];
  logic [ENT_W-1:0]     rdata_q;
  out_item_t            out_q;
  logic                 out_valid_q, out_valid_d;

  logic                 can_emit;
  logic                 emit_free;
  logic [Q_W-1:0]       qsel;
  logic [HEAD_W-1:0]    qhead;
  logic [FILL_W-1:0]    qfill;
  logic [FILL_W:0]      slot_sum;
  logic [HEAD_W-1:0]    slot;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic                 enq_ok;
  logic [SRV_W-1:0]     sidx;
  logic [DUR_W-1:0]     rem_n;
  logic [SRV_W-1:0]     srv;
  logic [TASK_W-1:0]    r_seq;
  logic [TIME_BITS-1:0] r_arr, wait_full;
  logic [DUR_W-1:0]     r_dur;

  assign can_emit    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cmd_pop_o   = (state_q == ST_END) && can_emit;

  // Queue selection: the new task's queue while enqueuing, else the scan pointer.
  assign qsel     = (state_q == ST_ENQ) ? cmd_i.item.queue_index : qptr_q[Q_W-1:0];
  assign qhead    = head_q[qsel];
  assign qfill    = fill_q[qsel];
  assign slot_sum = {1'b0, {(FILL_W - HEAD_W){1'b0}}, qhead} + {1'b0, qfill};
  assign slot     = (slot_sum >= (FILL_W + 1)'(QUEUE_DEPTH)) ?
                    HEAD_W'(slot_sum - (FILL_W + 1)'(QUEUE_DEPTH)) : HEAD_W'(slot_sum);
  assign wr_addr  = ADDR_W'(qsel * QUEUE_DEPTH) + ADDR_W'(slot);
  assign rd_addr  = ADDR_W'(qsel * QUEUE_DEPTH) + ADDR_W'(qhead);
  assign enq_ok   = cmd_i.item.new_task_valid && !cmd_i.inactive &&
                    (qfill < FILL_W'(QUEUE_DEPTH));

  // Countdown of the scanned server.
  assign sidx  = sptr_q[SRV_W-1:0];
  assign rem_n = (rem_q[sidx] != '0) ? rem_q[sidx] - DUR_W'(1) : '0;

  // A scanned busy server that reaches zero produces a free event.
  assign emit_free = (state_q == ST_SCAN) && (sptr_q < SCNT_W'(cfg_i.active_servers)) &&
                     busy_q[sidx] && (rem_n == '0);

  // The output register loads a new result or holds one that waits.
  assign out_valid_d = (can_emit && (emit_free || state_q == ST_START || state_q == ST_END)) ||
                       (out_valid_q && !out_ready_i);

  // Fields of the task read for a start.
  assign {r_seq, r_arr, r_dur} = rdata_q;
  assign wait_full = tick_q - r_arr;
  assign srv       = ffifo_q[0];

  // Sequencer state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (cmd_valid_i && !cfg_i.refill) state_d = ST_ENQ;
      ST_ENQ:   state_d = ST_SCAN;
      ST_SCAN: begin
        if (sptr_q >= SCNT_W'(cfg_i.active_servers)) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (qptr_q >= QCNT_W'(cfg_i.active_queues) || fcount_q == '0) begin
          state_d = ST_END;
        end else if (qfill != '0) begin
          state_d = ST_START;
        end
      end
      ST_START: if (can_emit) state_d = ST_LOAD;
      ST_END:   if (can_emit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control and server state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fcount_q    <= SCNT_W'(NUM_SERVERS);
      tick_q      <= '0;
      seq_q       <= '0;
      sptr_q      <= '0;
      qptr_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        rem_q[i]   <= '0;
        busy_q[i]  <= 1'b0;
        ffifo_q[i] <= SRV_W'(i);
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_i.refill) begin
            for (int i = 0; i < NUM_SERVERS; i++) begin
              busy_q[i]  <= 1'b0;
              rem_q[i]   <= '0;
              ffifo_q[i] <= (i < cfg_i.active_servers) ? SRV_W'(i) : '0;
            end
            fcount_q <= SCNT_W'(cfg_i.active_servers);
          end
        end
        ST_ENQ: begin
          drop_q <= cmd_i.item.new_task_valid && !enq_ok;
          if (enq_ok) begin
            fill_q[qsel] <= qfill + FILL_W'(1);
            seq_q        <= seq_q + TASK_W'(1);
          end
          sptr_q <= '0;
        end
        ST_SCAN: begin
          if (sptr_q < SCNT_W'(cfg_i.active_servers)) begin
            if (!busy_q[sidx]) begin
              sptr_q <= sptr_q + SCNT_W'(1);
            end else if (rem_n != '0) begin
              rem_q[sidx] <= rem_n;
              sptr_q      <= sptr_q + SCNT_W'(1);
            end else if (can_emit) begin
              rem_q[sidx]  <= '0;
              busy_q[sidx] <= 1'b0;
              if (fcount_q < SCNT_W'(NUM_SERVERS)) begin
                ffifo_q[fcount_q[SRV_W-1:0]] <= sidx;
                fcount_q <= fcount_q + SCNT_W'(1);
              end
              sptr_q      <= sptr_q + SCNT_W'(1);
            end
          end else begin
            qptr_q <= '0;
          end
        end
        ST_LOAD: begin
          if (!(qptr_q >= QCNT_W'(cfg_i.active_queues) || fcount_q == '0) && qfill == '0) begin
            qptr_q <= qptr_q + QCNT_W'(1);
          end
        end
        ST_START: begin
          if (can_emit) begin
            for (int i = 0; i < NUM_SERVERS - 1; i++) begin
              ffifo_q[i] <= ffifo_q[i + 1];
            end
            fcount_q     <= fcount_q - SCNT_W'(1);
            rem_q[srv]   <= r_dur;
            busy_q[srv]  <= 1'b1;
            head_q[qsel] <= (qhead == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : qhead + HEAD_W'(1);
            fill_q[qsel] <= qfill - FILL_W'(1);
          end
        end
        ST_END: begin
          if (can_emit) begin
            tick_q <= tick_q + TIME_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Result payload and task of each server.
  always_ff @(posedge clk_i) begin
    if (can_emit) begin
      if (emit_free) begin
        out_q <= '{event_kind: EV_FREE, server_index: sidx, task_id: stask_q[sidx],
                   source_queue: '0, wait_ticks: '0, task_dropped: 1'b0, last: 1'b0};
      end else if (state_q == ST_START) begin
        stask_q[srv] <= r_seq;
        out_q <= '{event_kind: EV_START, server_index: srv, task_id: r_seq,
                   source_queue: qsel, wait_ticks: WAIT_W'(wait_full),
                   task_dropped: 1'b0, last: 1'b0};
      end else if (state_q == ST_END) begin
        out_q <= '{event_kind: EV_END, server_index: '0, task_id: '0,
                   source_queue: '0, wait_ticks: '0, task_dropped: drop_q, last: 1'b1};
      end
    end
  end

  // Task store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ENQ && enq_ok) begin
      mem[wr_addr] <= {seq_q, tick_q, cmd_i.item.duration};
    end
    rdata_q <= mem[rd_addr];
  end

  a_start_has_server: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |-> (fcount_q != '0))
    else $error("start without a free server");

  a_start_has_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |-> (qfill != '0))
    else $error("start from an empty queue");

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= SCNT_W'(NUM_SERVERS))
    else $error("free list overflow");

  a_pop_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == ST_IDLE) && out_valid_q && out_q.last)
    else $error("tick closed without end item");

endmodule

// ----- hw/rtl/multi_server_task_dispatcher_unit.sv -----
// Top level of the multi-server task dispatcher: APB register file, front
// and back parts. Depends on msd_pkg, msd_front and msd_engine.
//
// Usage: each transfer on the input channel is one tick that may bring a
// task (queue index and duration). The block answers each tick with zero or
// more free events, zero or more start events and one end-of-tick item with
// last set, in that order, on the output channel.
// Sequencing: the sequencer in the back part visits one active server at a
// time, then passes over the active queues and loads one task at a time
// into a free server, and reads the task store through its single
// registered read port. Up to two ticks wait in the front queue while the
// back part works.
// Stall: when the receiver holds out_ready_i low the back part waits on its
// output register; the front keeps taking ticks until its queue fills.
// Reset: all servers idle, servers 0 to 7 free in order, queues empty,
// active_servers 8 and active_queues 1. Writing active_servers idles every
// server and refills the free list; write registers only while idle.
`timescale 1ns / 1ps

module multi_server_task_dispatcher_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msd_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import msd_pkg::*;

  logic [ASRV_W-1:0] asrv_q, asrv_d;
  logic [AQ_W-1:0]   aq_q, aq_d;
  logic              refill_q;
  logic              wr_en;
  cfg_t              cfg;
  cmd_t              cmd;
  logic              cmd_valid, cmd_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Saturate written values into their legal ranges.
  always_comb begin
    asrv_d = pwdata[ASRV_W-1:0];
    if (asrv_d == '0) asrv_d = ASRV_W'(1);
    if (asrv_d > ASRV_W'(NUM_SERVERS)) asrv_d = ASRV_W'(NUM_SERVERS);
    aq_d = pwdata[AQ_W-1:0];
    if (aq_d == '0) aq_d = AQ_W'(1);
    if (aq_d > AQ_W'(NUM_QUEUES)) aq_d = AQ_W'(NUM_QUEUES);
  end

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asrv_q   <= ASRV_W'(NUM_SERVERS);
      aq_q     <= AQ_W'(1);
      refill_q <= 1'b0;
    end else begin
      refill_q <= 1'b0;
      if (wr_en) begin
        case (paddr[2])
          REG_ACTIVE_SERVERS: begin
            asrv_q   <= asrv_d;
            refill_q <= 1'b1;
          end
          default: aq_q <= aq_d;
        endcase
      end
    end
  end

  // Read back.
  always_comb begin
    case (paddr[2])
      REG_ACTIVE_SERVERS: prdata = {{(32 - ASRV_W){1'b0}}, asrv_q};
      default:            prdata = {{(32 - AQ_W){1'b0}}, aq_q};
    endcase
  end

  assign cfg = '{active_servers: asrv_q, active_queues: aq_q, refill: refill_q};

  msd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .active_queues_i (aq_q),
    .cmd_valid_o     (cmd_valid),
    .cmd_pop_i       (cmd_pop),
    .cmd_o           (cmd)
  );

  msd_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule

// ----- tb/sv/tb_multi_server_task_dispatcher_unit.sv -----
// Testbench for the multi-server task dispatcher unit: predicts every result
// of each tick and checks it against the output channel. Depends on msd_pkg
// and multi_server_task_dispatcher_unit.
`timescale 1ns / 1ps

module tb_multi_server_task_dispatcher_unit;
  import msd_pkg::*;

  localparam int QDEPTH = 16;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  multi_server_task_dispatcher_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk_i = ~clk_i;

  // Dispatcher state as the predictor sees it.
  int unsigned n_servers;
  int unsigned n_queues;
  logic [15:0] srv_left [NUM_SERVERS];
  logic srv_busy [NUM_SERVERS];
  logic [15:0] srv_task [NUM_SERVERS];
  int unsigned free_list [NUM_SERVERS];
  int unsigned free_cnt;
  logic [15:0] q_seq [NUM_QUEUES][QDEPTH];
  logic [15:0] q_arrival [NUM_QUEUES][QDEPTH];
  logic [15:0] q_dur [NUM_QUEUES][QDEPTH];
  int unsigned q_fill [NUM_QUEUES];
  int unsigned q_head [NUM_QUEUES];
  logic [15:0] tick_now;
  logic [15:0] seq_next;

  out_item_t pending_events [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  function automatic out_item_t make_event(logic [1:0] kind, int unsigned srv,
                                           logic [15:0] task_no, int unsigned q,
                                           logic [15:0] waited, logic drop,
                                           logic fin);
    out_item_t e;
    e.event_kind = kind;
    e.server_index = srv[SRV_W-1:0];
    e.task_id = task_no;
    e.source_queue = q[Q_W-1:0];
    e.wait_ticks = waited;
    e.task_dropped = drop;
    e.last = fin;
    return e;
  endfunction

  // Appends one expected result to the tail of the list.
  function automatic void queue_event(out_item_t e);
    pending_events = {pending_events, e};
  endfunction

  // Idles every server and rebuilds the free list for the active count.
  function automatic void refill_free_list();
    for (int i = 0; i < NUM_SERVERS; i++) begin
      srv_left[i] = '0;
      srv_busy[i] = 1'b0;
      free_list[i] = (i < n_servers) ? i : 0;
    end
    free_cnt = n_servers;
  endfunction

  function automatic void reset_dispatcher();
    n_servers = NUM_SERVERS;
    n_queues = 1;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      q_fill[q] = 0;
      q_head[q] = 0;
    end
    tick_now = '0;
    seq_next = '0;
    refill_free_list();
  endfunction

  // Computes the events of one tick and queues them as expected results.
  function automatic void predict_tick(in_item_t it);
    logic drop;
    int unsigned slot;
    int unsigned srv;
    drop = 1'b0;
    if (it.new_task_valid) begin
      if (it.queue_index >= n_queues || q_fill[it.queue_index] >= QDEPTH) begin
        drop = 1'b1;
      end else begin
        slot = (q_head[it.queue_index] + q_fill[it.queue_index]) % QDEPTH;
        q_seq[it.queue_index][slot] = seq_next;
        q_arrival[it.queue_index][slot] = tick_now;
        q_dur[it.queue_index][slot] = it.duration;
        q_fill[it.queue_index]++;
        seq_next++;
      end
    end
    // Busy servers count down in index order.
    for (int s = 0; s < n_servers; s++) begin
      if (srv_busy[s]) begin
        if (srv_left[s] > 0) srv_left[s]--;
        if (srv_left[s] == 0) begin
          srv_busy[s] = 1'b0;
          if (free_cnt < NUM_SERVERS) begin
            free_list[free_cnt] = s;
            free_cnt++;
          end
          queue_event(make_event(EV_FREE, s, srv_task[s], 0, '0, 1'b0, 1'b0));
        end
      end
    end
    // Free servers take tasks from the lowest non-empty queue first.
    for (int q = 0; q < n_queues; q++) begin
      while (free_cnt > 0 && q_fill[q] > 0) begin
        srv = free_list[0];
        for (int i = 1; i < free_cnt; i++) free_list[i-1] = free_list[i];
        free_cnt--;
        slot = q_head[q];
        srv_task[srv] = q_seq[q][slot];
        srv_left[srv] = q_dur[q][slot];
        srv_busy[srv] = 1'b1;
        q_head[q] = (slot + 1) % QDEPTH;
        q_fill[q]--;
        queue_event(make_event(EV_START, srv, srv_task[srv], q,
                               tick_now - q_arrival[q][slot], 1'b0, 1'b0));
      end
    end
    tick_now++;
    queue_event(make_event(EV_END, 0, '0, 0, '0, drop, 1'b1));
  endfunction

  // Sends one tick over the input channel and predicts its results.
  task automatic send_tick(logic valid_task, int unsigned q, int unsigned dur);
    in_item_t it;
    it.new_task_valid = valid_task;
    it.queue_index = q[Q_W-1:0];
    it.duration = dur[DUR_W-1:0];
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_tick(it);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Writes one register through the APB port.
  task automatic write_reg(logic index, int unsigned value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_ACTIVE_SERVERS) begin
      n_servers = (value & 15) < 1 ? 1 : ((value & 15) > NUM_SERVERS ? NUM_SERVERS : (value & 15));
      refill_free_list();
    end else begin
      n_queues = (value & 7) < 1 ? 1 : ((value & 7) > NUM_QUEUES ? NUM_QUEUES : (value & 7));
    end
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  task automatic drain();
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned servers, int unsigned queues);
    drain();
    write_reg(REG_ACTIVE_SERVERS, servers);
    write_reg(REG_ACTIVE_QUEUES, queues);
  endtask

  // Directed: field extremes, drops on inactive queues, zero duration.
  task automatic test_directed();
    send_tick(1'b1, 0, 0);
    send_tick(1'b1, 0, 16'hffff);
    send_tick(1'b1, 3, 1);
    send_tick(1'b0, 3, 16'hffff);
    set_config(1, 4);
    for (int i = 0; i < 18; i++) send_tick(1'b1, 2, 3);
    set_config(0, 0);
    send_tick(1'b1, 0, 2);
    send_tick(1'b1, 1, 2);
    set_config(15, 7);
    send_tick(1'b0, 0, 0);
    send_tick(1'b1, 3, 1);
    repeat (5) send_tick(1'b0, 0, 0);
  endtask

  // Random ticks: bursts of short tasks over all queues, with quiet ticks.
  task automatic test_random(int count);
    int unsigned dur;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: dur = $urandom_range(16'hffff);
        1: dur = 0;
        default: dur = $urandom_range(12);
      endcase
      send_tick($urandom_range(3) != 0, $urandom_range(3), dur);
    end
  endtask

  // Receiver holds off long enough for the front queue to fill.
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      test_random(30);
    join
  endtask

  // Output channel driver.
  always @(negedge clk_i) begin
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    out_item_t exp_ev;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_ev = pending_events[0];
        pending_events.delete(0);
        if (exp_ev !== out_data_o) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_ev, out_data_o);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || recv_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reset_dispatcher();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 10;
    recv_idle_pct = 47;
    test_directed();
    set_config(8, 4);
    test_random(130);
    send_idle_pct = 47;
    recv_idle_pct = 10;
    set_config(3, 2);
    test_random(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(8, 4);
    test_backpressure();
    test_random(110);
    drain();
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
